/* rtl/circular_byte_queue_top_assert.svh */
// ----------------------------------------------------------------------------
// circular byte queue assertion macros
// checks on the top level, sampled on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_BYTE_QUEUE_TOP_ASSERT_SVH
`define CIRCULAR_BYTE_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define CBQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cbq_pkg.sv */
// ----------------------------------------------------------------------------
// cbq_pkg
// shared types and constants of the circular byte queue
// ----------------------------------------------------------------------------
package cbq_pkg;

  localparam int Depth = 256;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    MODE_ENQ      = 3'd0,
    MODE_DEQ      = 3'd1,
    MODE_PEEK     = 3'd2,
    MODE_PEEK_IDX = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ERROR = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            use_rd;
    logic [CntW-1:0] fill_count;
    logic [CntW-1:0] free_space;
    logic            is_empty;
    logic            is_full;
  } result_t;

endpackage

/* rtl/cbq_if.sv */
// ----------------------------------------------------------------------------
// cbq channel interfaces
// request, response and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface cbq_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] data_in;
  logic [7:0] index;

  modport source (output valid, mode, data_in, index, input ready);
  modport sink (input valid, mode, data_in, index, output ready);
endinterface

interface cbq_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] data_out;
  logic [8:0] fill_count;
  logic [8:0] free_space;
  logic       is_empty;
  logic       is_full;

  modport source (output valid, status, data_out, fill_count, free_space, is_empty,
                  is_full, input ready);
  modport sink (input valid, status, data_out, fill_count, free_space, is_empty,
                is_full, output ready);
endinterface

interface cbq_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink (input valid, capacity_in_use, output ready);
endinterface

/* rtl/cbq_ram.sv */
// ----------------------------------------------------------------------------
// cbq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cbq_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cbq_ctrl.sv */
// ----------------------------------------------------------------------------
// cbq_ctrl
// head, tail, count and capacity registers; decodes one item per accept
// ----------------------------------------------------------------------------
module cbq_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [2:0]               mode,
  input  logic [7:0]               data_in,
  input  logic [7:0]               index,
  input  logic                     cfg_we,
  input  logic [8:0]               cfg_cap,
  output logic                     ram_we,
  output logic [cbq_pkg::PtrW-1:0] ram_waddr,
  output logic [7:0]               ram_wdata,
  output logic [cbq_pkg::PtrW-1:0] ram_raddr,
  output cbq_pkg::result_t         res
);
  import cbq_pkg::*;

  logic [PtrW-1:0] head, head_next;
  logic [PtrW-1:0] tail, tail_next;
  logic [CntW-1:0] count, count_next;
  logic [CntW-1:0] cap, cap_wr;
  logic [1:0]      status;
  logic            use_rd;

  function automatic logic [PtrW-1:0] wrap_add(input logic [PtrW-1:0] p,
                                               input logic [PtrW-1:0] n,
                                               input logic [CntW-1:0] c);
    logic [CntW-1:0] s;
    s = CntW'(p) + CntW'(n);
    if (s >= c) begin
      s = s - c;
    end
    return s[PtrW-1:0];
  endfunction

  always_comb begin
    if (cfg_cap == '0) begin
      cap_wr = CntW'(1);
    end else if (CntW'(cfg_cap) > CntW'(Depth)) begin
      cap_wr = CntW'(Depth);
    end else begin
      cap_wr = CntW'(cfg_cap);
    end
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    status     = ST_OK;
    use_rd     = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = head;
    case (mode)
      MODE_ENQ: begin
        if (count >= cap) begin
          status = ST_FULL;
        end else begin
          ram_we     = go;
          tail_next  = wrap_add(tail, PtrW'(1), cap);
          count_next = count + CntW'(1);
        end
      end
      MODE_DEQ: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else begin
          use_rd     = 1'b1;
          head_next  = wrap_add(head, PtrW'(1), cap);
          count_next = count - CntW'(1);
        end
      end
      MODE_PEEK: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else begin
          use_rd = 1'b1;
        end
      end
      MODE_PEEK_IDX: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else if (CntW'(index) >= count) begin
          status = ST_ERROR;
        end else begin
          use_rd    = 1'b1;
          ram_raddr = wrap_add(head, PtrW'(index), cap);
        end
      end
      MODE_CLEAR: begin
        head_next  = '0;
        tail_next  = '0;
        count_next = '0;
      end
      default: begin
        status = ST_ERROR;
      end
    endcase
  end

  assign ram_waddr = tail;
  assign ram_wdata = data_in;

  assign res.status     = status;
  assign res.use_rd     = use_rd;
  assign res.fill_count = count_next;
  assign res.free_space = cap - count_next;
  assign res.is_empty   = (count_next == '0);
  assign res.is_full    = (count_next == cap);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      cap   <= CntW'(Depth);
    end else if (cfg_we) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      cap   <= cap_wr;
    end else if (go) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

endmodule

/* rtl/circular_byte_queue_top.sv */
// ----------------------------------------------------------------------------
// circular_byte_queue_top
// result: an accepted item is held in the pend register, then moves to the output
//   register with rsp.valid; a single item is in flight between accept and the output
//   register, so req.ready is low while it is pending or the output is not taken
// reset: rst clears pointers and count, capacity returns to 256;
//   ram contents are not cleared
// ----------------------------------------------------------------------------
`include "circular_byte_queue_top_assert.svh"

module circular_byte_queue_top (
  input logic clk,
  input logic rst,
  cbq_req_if.sink   req,
  cbq_rsp_if.source rsp,
  cbq_cfg_if.sink   cfg
);
  import cbq_pkg::*;

  logic            go;
  logic            pend;
  result_t         res;
  result_t         pend_res;
  logic            ram_we;
  logic [PtrW-1:0] ram_waddr;
  logic [7:0]      ram_wdata;
  logic [PtrW-1:0] ram_raddr;
  logic [7:0]      ram_rdata;

  assign req.ready = !pend && (!rsp.valid || rsp.ready);
  assign go        = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  cbq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .mode      (req.mode),
    .data_in   (req.data_in),
    .index     (req.index),
    .cfg_we    (cfg.valid),
    .cfg_cap   (cfg.capacity_in_use),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .res       (res)
  );

  cbq_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (go) begin
      pend_res <= res;
    end
    if (pend) begin
      rsp.status     <= pend_res.status;
      rsp.data_out   <= pend_res.use_rd ? ram_rdata : 8'd0;
      rsp.fill_count <= pend_res.fill_count;
      rsp.free_space <= pend_res.free_space;
      rsp.is_empty   <= pend_res.is_empty;
      rsp.is_full    <= pend_res.is_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      pend <= go;
      if (pend) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  `CBQ_ASSERT_NEXT(a_pend_to_out, pend, rsp.valid, "pending item did not reach output")
  `CBQ_ASSERT_NOW(a_full_flag, rsp.valid, rsp.is_full == (rsp.free_space == '0), "full flag mismatch")
  `CBQ_ASSERT_NOW(a_empty_flag, rsp.valid, rsp.is_empty == (rsp.fill_count == '0), "empty flag mismatch")
  `CBQ_ASSERT_NOW(a_data_zero, rsp.valid && (rsp.status != ST_OK), rsp.data_out == 8'd0, "data on failed item")

endmodule
